// File: hw/rtl/ssw_pkg.sv
// Shared constants, tables and types of the scan search window core.
package ssw_pkg;

   // Field and register widths.
   localparam int PT_W      = 24;
   localparam int ANG_W     = 16;
   localparam int CNT_W     = 13;
   localparam int DEG_W     = 17;
   localparam int LIN_W     = 22;
   localparam int IDX_W     = 12;
   localparam int CSR_W     = 22;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_W     = 2 * PT_W;
   localparam int RSP_W     = 2 * IDX_W;

   // Largest number of rays in a scan.
   localparam int RAY_MAX = 4096;

   // Angular slack conversion: |deg| * pi(Q29) / (180 * 256), rounded to Q13.
   // The divisor 180 * 256 * 2^16 is 45 * 2^26.
   localparam logic [30:0] PI_Q29      = 31'd1686629713;
   localparam logic [30:0] ANG_ROUND   = 31'd1509949440;
   localparam int          ANG_SHIFT   = 26;
   localparam logic [5:0]  DEG_ODD_DIV = 6'd45;
   localparam logic [26:0] RECIP_45    = 27'd95443717;

   localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
   localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;

   // Vectoring CORDIC: arctangent table in units of 2^-16 rad.
   localparam int CORDIC_STEPS = 17;
   localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
   localparam int ATAN_TAB [CORDIC_STEPS] = '{
      51472, 30385, 16055, 8150, 4091, 2047, 1024, 512, 256,
      128, 64, 32, 16, 8, 4, 2, 1
   };

   // Square root of the squared radius, one result bit per stage.
   localparam int SQ_IN_W  = 2 * PT_W;
   localparam int SQRT_LAT = SQ_IN_W / 2;

   // Restoring divider, one quotient bit per stage.
   localparam int DIV_W   = 29;
   localparam int DIV_LAT = DIV_W;

   // Configuration register indices.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_ANGLE = 3'd0,
      CSR_MAX_ANGLE = 3'd1,
      CSR_RAY_COUNT = 3'd2,
      CSR_ANG_SLACK = 3'd3,
      CSR_LIN_SLACK = 3'd4
   } csr_index_type;

endpackage

// File: hw/rtl/scan_search_window_core.sv
// Top level of the scan search window core: ray index window for one scan point.
//
//  channel | direction | contents
//  --------+-----------+---------------------------------------------
//  req_    | in        | point_x [23:0], point_y [47:24]
//  rsp_    | out       | first_ray [11:0], last_ray [23:12]
//  csr_    | in        | write enable, register index, write data
//
// One request is taken per cycle while req_tready is high; each result passes through
// the 24-stage square root, the 19-stage CORDIC and the 29-stage divider in series.
// Reset clears all valid bits and loads the register defaults.
// A result that is not taken waits in the output register; a second one goes into
// a skid register, and while that is full the pipeline holds and req_tready is low.
module scan_search_window_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ssw_pkg::REQ_W-1:0]       req_tdata,   // point_x, point_y
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ssw_pkg::RSP_W-1:0]       rsp_tdata,   // first_ray, last_ray
   input  logic                            csr_we,
   input  logic [ssw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ssw_pkg::CSR_W-1:0]       csr_wdata
);
   import ssw_pkg::*;

   localparam int ST_RAD    = 2;
   localparam int ST_ROOT   = ST_RAD + SQRT_LAT;
   localparam int ST_LTERM  = ST_ROOT + CORDIC_LAT;
   localparam int ST_MAG    = ST_LTERM + 3;
   localparam int ST_QUO    = ST_MAG + DIV_LAT;
   localparam int LAST      = ST_QUO + 1;
   localparam int BEAR_DLY  = ST_LTERM - CORDIC_LAT;

   // Configuration registers.
   logic [ANG_W-1:0] amin_ff;
   logic [ANG_W-1:0] amax_ff;
   logic [CNT_W-1:0] rays_ff;
   logic [DEG_W-1:0] deg_ff;
   logic [LIN_W-1:0] lin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         amin_ff <= ANG_W'(-12868);
         amax_ff <= ANG_W'(12868);
         rays_ff <= CNT_W'(181);
         deg_ff  <= DEG_W'(2560);
         lin_ff  <= LIN_W'(32768);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_ANGLE: amin_ff <= csr_wdata[ANG_W-1:0];
            CSR_MAX_ANGLE: amax_ff <= csr_wdata[ANG_W-1:0];
            CSR_RAY_COUNT: rays_ff <= csr_wdata[CNT_W-1:0];
            CSR_ANG_SLACK: deg_ff  <= csr_wdata[DEG_W-1:0];
            CSR_LIN_SLACK: lin_ff  <= csr_wdata[LIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Values that follow from the registers alone.
   logic signed [ANG_W:0]   span;
   logic                    span_pos;
   logic [CNT_W-1:0]        n_eff;
   logic signed [DEG_W-1:0] deg_s;
   logic [DEG_W-1:0]        deg_abs;
   logic signed [LIN_W-1:0] lin_s;
   logic [LIN_W-1:0]        lin_abs;

   assign span     = (ANG_W+1)'(signed'(amax_ff)) - (ANG_W+1)'(signed'(amin_ff));
   assign span_pos = (span > 0);
   assign deg_s    = signed'(deg_ff);
   assign deg_abs  = (deg_s < 0) ? DEG_W'(-deg_s) : deg_ff;
   assign lin_s    = signed'(lin_ff);
   assign lin_abs  = (lin_s < 0) ? LIN_W'(-lin_s) : lin_ff;

   always_comb begin
      if (rays_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (rays_ff > CNT_W'(RAY_MAX)) begin
         n_eff = CNT_W'(RAY_MAX);
      end else begin
         n_eff = rays_ff;
      end
   end

   // Angular slack in Q3.13, refreshed every cycle from the register.
   logic [47:0] angp_ff;
   logic [21:0] angv_ff;
   logic [21:0] angv2_ff;
   logic [48:0] angm_ff;
   logic [16:0] angq;
   logic [21:0] ang_rem;
   logic [16:0] ang_ff;

   assign angq    = angm_ff[48:32];
   assign ang_rem = angv2_ff - 22'(angq) * 22'(DEG_ODD_DIV);

   always_ff @(posedge clock) begin
      angp_ff  <= 48'(deg_abs) * 48'(PI_Q29);
      angv_ff  <= 22'((angp_ff + 48'(ANG_ROUND)) >> ANG_SHIFT);
      angv2_ff <= angv_ff;
      angm_ff  <= 49'(angv_ff) * 49'(RECIP_45);
      if (ang_rem >= 22'(DEG_ODD_DIV)) begin
         ang_ff <= angq + 17'd1;
      end else begin
         ang_ff <= angq;
      end
   end

   // Stall control: the pipeline moves while the skid register is empty.
   logic en;
   logic valid_ff [LAST+1];
   logic out_valid_ff;
   logic skid_valid_ff;
   logic [RSP_W-1:0] out_data_ff;
   logic [RSP_W-1:0] skid_data_ff;
   logic [RSP_W-1:0] res_ff;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LAST; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= req_tvalid;
         for (int k = 1; k <= LAST; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // Input register and squared radius.
   logic signed [PT_W-1:0]    px_ff;
   logic signed [PT_W-1:0]    py_ff;
   logic signed [SQ_IN_W-1:0] sqx_ff;
   logic signed [SQ_IN_W-1:0] sqy_ff;
   logic [SQ_IN_W-1:0]        rad_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff  <= signed'(req_tdata[PT_W-1:0]);
         py_ff  <= signed'(req_tdata[REQ_W-1:PT_W]);
         sqx_ff <= SQ_IN_W'(px_ff) * SQ_IN_W'(px_ff);
         sqy_ff <= SQ_IN_W'(py_ff) * SQ_IN_W'(py_ff);
         rad_ff <= SQ_IN_W'(sqx_ff + sqy_ff);
      end
   end

   // Distance of the point.
   logic [SQRT_LAT-1:0] root;

   ssw_isqrt u_isqrt (
      .clock (clock),
      .en    (en),
      .rad   (rad_ff),
      .root  (root)
   );

   // Linear term atan(|linear slack| / distance) and the point's bearing.
   logic signed [16:0] lterm;
   logic signed [16:0] bearing;

   ssw_cordic u_cordic_lin (
      .clock (clock),
      .en    (en),
      .vec_y (signed'({3'b000, lin_abs})),
      .vec_x (signed'({1'b0, root})),
      .angle (lterm)
   );

   ssw_cordic u_cordic_bear (
      .clock (clock),
      .en    (en),
      .vec_y (25'(py_ff)),
      .vec_x (25'(px_ff)),
      .angle (bearing)
   );

   // Delay lines that line the side values up with the linear term.
   logic signed [16:0] bear_dly_ff [BEAR_DLY];
   logic               r0_dly_ff   [CORDIC_LAT];
   logic [1:0]         neg_dly_ff  [DIV_LAT+1];

   always_ff @(posedge clock) begin
      if (en) begin
         bear_dly_ff[0] <= bearing;
         for (int k = 1; k < BEAR_DLY; k++) begin
            bear_dly_ff[k] <= bear_dly_ff[k-1];
         end
         r0_dly_ff[0] <= (root == '0);
         for (int k = 1; k < CORDIC_LAT; k++) begin
            r0_dly_ff[k] <= r0_dly_ff[k-1];
         end
      end
   end

   // Half-width and offset from the first ray, then scaled by the ray count.
   logic signed [17:0] delta_ff;
   logic signed [17:0] bdiff_ff;
   logic signed [31:0] rprod_ff;
   logic signed [31:0] sprod_ff;
   logic [DIV_W-1:0]   rmag_ff;
   logic [DIV_W-1:0]   smag_ff;
   logic signed [16:0] lterm_sel;
   logic signed [31:0] n_s;

   assign lterm_sel = r0_dly_ff[CORDIC_LAT-1] ? HALF_PI_Q13 : lterm;
   assign n_s       = signed'({19'd0, n_eff});

   // The sign flags travel beside the divider and leave with its quotient.
   always_ff @(posedge clock) begin
      if (en) begin
         delta_ff <= 18'(signed'({1'b0, ang_ff})) + 18'(lterm_sel);
         bdiff_ff <= 18'(bear_dly_ff[BEAR_DLY-1]) - 18'(signed'(amin_ff));
         rprod_ff <= 32'(delta_ff) * n_s + 32'(span) - 32'sd1;
         sprod_ff <= 32'(bdiff_ff) * n_s;
         rmag_ff  <= (rprod_ff < 0) ? DIV_W'(-rprod_ff) : DIV_W'(rprod_ff);
         smag_ff  <= (sprod_ff < 0) ? DIV_W'(-sprod_ff) : DIV_W'(sprod_ff);
         neg_dly_ff[0] <= {sprod_ff < 0, rprod_ff < 0};
         for (int k = 1; k <= DIV_LAT; k++) begin
            neg_dly_ff[k] <= neg_dly_ff[k-1];
         end
      end
   end

   // Cell count and start cell, both truncated toward zero.
   logic [DIV_W-1:0] rquo;
   logic [DIV_W-1:0] squo;

   ssw_divide u_div_range (
      .clock (clock),
      .en    (en),
      .num   (rmag_ff),
      .den   (span[ANG_W-1:0]),
      .quo   (rquo)
   );

   ssw_divide u_div_start (
      .clock (clock),
      .en    (en),
      .num   (smag_ff),
      .den   (span[ANG_W-1:0]),
      .quo   (squo)
   );

   // Widen by the cell count and clamp both ends to the scan; a span that is not positive gives the whole scan.
   logic signed [31:0] range_v;
   logic signed [31:0] start_v;
   logic signed [31:0] lo;
   logic signed [31:0] hi;
   logic signed [31:0] nm1;
   logic [IDX_W-1:0]   first_in;
   logic [IDX_W-1:0]   last_in;

   always_comb begin
      range_v = signed'({3'd0, rquo});
      start_v = signed'({3'd0, squo});
      if (neg_dly_ff[DIV_LAT][0]) begin
         range_v = -range_v;
      end
      if (neg_dly_ff[DIV_LAT][1]) begin
         start_v = -start_v;
      end
      nm1 = n_s - 32'sd1;
      lo  = start_v - range_v;
      hi  = start_v + range_v;
      if (lo < 0) begin
         lo = '0;
      end else if (lo > nm1) begin
         lo = nm1;
      end
      if (hi < 0) begin
         hi = '0;
      end else if (hi > nm1) begin
         hi = nm1;
      end
      if (span_pos) begin
         first_in = lo[IDX_W-1:0];
         last_in  = hi[IDX_W-1:0];
      end else begin
         first_in = '0;
         last_in  = nm1[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= {last_in, first_in};
      end
   end

   // Output register with skid stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_tready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_ff <= valid_ff[LAST];
      end else if (valid_ff[LAST]) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (!out_valid_ff || rsp_tready) begin
         out_data_ff <= res_ff;
      end else begin
         skid_data_ff <= res_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// File: hw/rtl/ssw_isqrt.sv
// Pipelined integer square root, one root bit resolved per stage.
module ssw_isqrt (
   input  logic                          clock,
   input  logic                          en,
   input  logic [ssw_pkg::SQ_IN_W-1:0]   rad,
   output logic [ssw_pkg::SQRT_LAT-1:0]  root
);
   import ssw_pkg::*;

   localparam int RT_W  = SQRT_LAT;
   localparam int REM_W = RT_W + 1;

   logic [SQ_IN_W-1:0] src_s  [SQRT_LAT];
   logic [REM_W-1:0]   rem_s  [SQRT_LAT];
   logic [RT_W-1:0]    root_s [SQRT_LAT];

   logic [SQ_IN_W-1:0] src_ff  [SQRT_LAT-1];
   logic [REM_W-1:0]   rem_ff  [SQRT_LAT-1];
   logic [RT_W-1:0]    root_ff [SQRT_LAT];

   genvar k;
   generate
      for (k = 0; k < SQRT_LAT; k++) begin : g_stage
         logic [REM_W+1:0] shifted;
         logic [REM_W+1:0] trial;
         logic             fits;

         // The first stage starts from the radicand with an empty root.
         if (k == 0) begin : g_first
            assign src_s[k]  = rad;
            assign rem_s[k]  = '0;
            assign root_s[k] = '0;
         end else begin : g_next
            assign src_s[k]  = src_ff[k-1];
            assign rem_s[k]  = rem_ff[k-1];
            assign root_s[k] = root_ff[k-1];
         end

         // Bring down two bits and try the next root bit.
         assign shifted = {rem_s[k], src_s[k][SQ_IN_W-1 -: 2]};
         assign trial   = {1'b0, root_s[k], 2'b01};
         assign fits    = (shifted >= trial);

         always_ff @(posedge clock) begin
            if (en) begin
               root_ff[k] <= {root_s[k][RT_W-2:0], fits};
            end
         end

         if (k < SQRT_LAT - 1) begin : g_carry
            always_ff @(posedge clock) begin
               if (en) begin
                  src_ff[k] <= src_s[k] << 2;
                  if (fits) begin
                     rem_ff[k] <= REM_W'(shifted - trial);
                  end else begin
                     rem_ff[k] <= REM_W'(shifted);
                  end
               end
            end
         end
      end
   endgenerate

   assign root = root_ff[SQRT_LAT-1];

endmodule

// File: hw/rtl/ssw_cordic.sv
// Pipelined vectoring CORDIC giving atan2(y, x) in Q3.13 radians.
module ssw_cordic (
   input  logic               clock,
   input  logic               en,
   input  logic signed [24:0] vec_y,
   input  logic signed [24:0] vec_x,
   output logic signed [16:0] angle
);
   import ssw_pkg::*;

   localparam int XY_W = 48;
   localparam int Z_W  = 20;

   logic signed [XY_W-1:0] xs;
   logic signed [XY_W-1:0] ys;
   logic signed [XY_W-1:0] x0_in;
   logic signed [XY_W-1:0] y0_in;
   logic signed [Z_W-1:0]  z0_in;

   logic signed [XY_W-1:0] x_ff    [CORDIC_STEPS];
   logic signed [XY_W-1:0] y_ff    [CORDIC_STEPS];
   logic signed [Z_W-1:0]  z_ff    [CORDIC_STEPS+1];
   logic                   zero_ff [CORDIC_STEPS+1];
   logic signed [16:0]     angle_ff;
   logic signed [Z_W-1:0]  z_round;

   // Scale up and fold the left half-plane onto the right one.
   assign xs = XY_W'(vec_x) <<< 20;
   assign ys = XY_W'(vec_y) <<< 20;

   always_comb begin
      x0_in = xs;
      y0_in = ys;
      z0_in = '0;
      if (vec_x < 0) begin
         if (vec_y >= 0) begin
            x0_in = ys;
            y0_in = -xs;
            z0_in = HALF_PI_Q16;
         end else begin
            x0_in = -ys;
            y0_in = xs;
            z0_in = -HALF_PI_Q16;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         zero_ff[0] <= (vec_x == 0) && (vec_y == 0);
      end
   end

   // One micro-rotation per stage, driving y towards zero.
   genvar k;
   generate
      for (k = 0; k < CORDIC_STEPS; k++) begin : g_iter
         logic signed [XY_W-1:0] dx;
         logic signed [XY_W-1:0] dy;
         logic                   up;

         assign dx = x_ff[k] >>> k;
         assign dy = y_ff[k] >>> k;
         assign up = (y_ff[k] > 0);

         always_ff @(posedge clock) begin
            if (en) begin
               zero_ff[k+1] <= zero_ff[k];
               if (up) begin
                  z_ff[k+1] <= z_ff[k] + Z_W'(ATAN_TAB[k]);
               end else begin
                  z_ff[k+1] <= z_ff[k] - Z_W'(ATAN_TAB[k]);
               end
            end
         end

         if (k < CORDIC_STEPS - 1) begin : g_xy
            always_ff @(posedge clock) begin
               if (en) begin
                  if (up) begin
                     x_ff[k+1] <= x_ff[k] + dy;
                     y_ff[k+1] <= y_ff[k] - dx;
                  end else begin
                     x_ff[k+1] <= x_ff[k] - dy;
                     y_ff[k+1] <= y_ff[k] + dx;
                  end
               end
            end
         end
      end
   endgenerate

   // Round from 2^-16 to 2^-13 rad; the origin gives zero.
   assign z_round = (z_ff[CORDIC_STEPS] + Z_W'(4)) >>> 3;

   always_ff @(posedge clock) begin
      if (en) begin
         if (zero_ff[CORDIC_STEPS]) begin
            angle_ff <= '0;
         end else begin
            angle_ff <= 17'(z_round);
         end
      end
   end

   assign angle = angle_ff;

endmodule

// File: hw/rtl/ssw_divide.sv
// Pipelined restoring divider, one quotient bit per stage.
module ssw_divide (
   input  logic                       clock,
   input  logic                       en,
   input  logic [ssw_pkg::DIV_W-1:0]  num,
   input  logic [15:0]                den,
   output logic [ssw_pkg::DIV_W-1:0]  quo
);
   import ssw_pkg::*;

   logic [DIV_W-1:0] num_s [DIV_LAT];
   logic [15:0]      rem_s [DIV_LAT];
   logic [DIV_W-1:0] quo_s [DIV_LAT];

   logic [DIV_W-1:0] num_ff [DIV_LAT-1];
   logic [15:0]      rem_ff [DIV_LAT-1];
   logic [DIV_W-1:0] quo_ff [DIV_LAT];

   genvar k;
   generate
      for (k = 0; k < DIV_LAT; k++) begin : g_stage
         logic [16:0] shifted;
         logic        fits;

         if (k == 0) begin : g_first
            assign num_s[k] = num;
            assign rem_s[k] = '0;
            assign quo_s[k] = '0;
         end else begin : g_next
            assign num_s[k] = num_ff[k-1];
            assign rem_s[k] = rem_ff[k-1];
            assign quo_s[k] = quo_ff[k-1];
         end

         // Bring down the next dividend bit and compare with the divisor.
         assign shifted = {rem_s[k], num_s[k][DIV_W-1]};
         assign fits    = (shifted >= {1'b0, den});

         always_ff @(posedge clock) begin
            if (en) begin
               quo_ff[k] <= {quo_s[k][DIV_W-2:0], fits};
            end
         end

         if (k < DIV_LAT - 1) begin : g_carry
            always_ff @(posedge clock) begin
               if (en) begin
                  num_ff[k] <= num_s[k] << 1;
                  if (fits) begin
                     rem_ff[k] <= 16'(shifted - {1'b0, den});
                  end else begin
                     rem_ff[k] <= shifted[15:0];
                  end
               end
            end
         end
      end
   endgenerate

   assign quo = quo_ff[DIV_LAT-1];

endmodule
